[src/pugd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pugd_pkg
// Shared types, constants and the angle table of the phase unwrap and
// group delay core.
// ----------------------------------------------------------------------------
package pugd_pkg;

	// default sample width and vectoring step count
	localparam int SAMPLE_BITS_DEF  = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	// fixed field widths
	localparam int FREQ_W  = 32;
	localparam int PHASE_W = 32;
	localparam int DELAY_W = 32;

	// round(pi * 2^28), thirty bits wide
	localparam int          PI_W   = 30;
	localparam logic [29:0] PI_Q28 = 30'd843314857;

	// width of the working vector and of the angle accumulator
	localparam int CW = 52;
	localparam int ZW = 18;

	// one result as handed to the output channel
	typedef struct packed {
		logic [PHASE_W-1:0] unwrapped_phase;
		logic [DELAY_W-1:0] phase_delay_out;
		logic [DELAY_W-1:0] group_delay_out;
		logic               sat_flag;
		logic               final_result;
	} pugd_res_t;

	// arctangent of 2^-i in phase units, 32768 units equal pi
	function automatic logic [ZW-1:0] atan_units(input logic [4:0] i);
		logic [ZW-1:0] v;
		begin
			unique case (i)
				5'd0:    v = ZW'(8192);
				5'd1:    v = ZW'(4836);
				5'd2:    v = ZW'(2555);
				5'd3:    v = ZW'(1297);
				5'd4:    v = ZW'(651);
				5'd5:    v = ZW'(326);
				5'd6:    v = ZW'(163);
				5'd7:    v = ZW'(81);
				5'd8:    v = ZW'(41);
				5'd9:    v = ZW'(20);
				5'd10:   v = ZW'(10);
				5'd11:   v = ZW'(5);
				5'd12:   v = ZW'(3);
				5'd13:   v = ZW'(1);
				5'd14:   v = ZW'(1);
				default: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage

[src/pugd_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pugd_in_if
// Request channel carrying one complex response point and its frequency.
// ----------------------------------------------------------------------------
interface pugd_in_if import pugd_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] resp_real;
	logic signed [SAMPLE_BITS-1:0] resp_imag;
	logic        [FREQ_W-1:0]      ang_freq;
	logic                          sweep_end;

	modport source (output valid, resp_real, resp_imag, ang_freq, sweep_end, input ready);
	modport sink   (input valid, resp_real, resp_imag, ang_freq, sweep_end, output ready);
endinterface

[src/pugd_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pugd_out_if
// Result channel carrying unwrapped phase, phase delay and group delay.
// ----------------------------------------------------------------------------
interface pugd_out_if import pugd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [PHASE_W-1:0] unwrapped_phase;
	logic signed [DELAY_W-1:0] phase_delay_out;
	logic signed [DELAY_W-1:0] group_delay_out;
	logic                      sat_flag;
	logic                      final_result;

	modport source (output valid, unwrapped_phase, phase_delay_out, group_delay_out,
		sat_flag, final_result, input ready);
	modport sink   (input valid, unwrapped_phase, phase_delay_out, group_delay_out,
		sat_flag, final_result, output ready);
endinterface

[src/phase_unwrap_group_delay_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_unwrap_group_delay_core
// Vectoring CORDIC phase, unwrap, and phase and group delay by a shared
// shift-add multiplier and restoring divider, one request at a time.
// ----------------------------------------------------------------------------
//  channel  dir  contents
//  sample   in   resp_real, resp_imag, ang_freq, sweep_end
//  result   out  unwrapped_phase, phase/group delay, sat_flag, final_result
//
//  A point runs the vectoring CORDIC (skipped for a zero sample) and an unwrap
//  step for the phase, then per delay 30 multiply steps and up to 34 divide
//  steps; up to four delays per point. Results lag one point. arst_n clears
//  sweep state and output valid. A stalled result holds its register; the
//  next result waits for it.
// ----------------------------------------------------------------------------
module phase_unwrap_group_delay_core import pugd_pkg::*; #(
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pugd_in_if.sink    sample,
	pugd_out_if.source result
);

	localparam int SCALE = 48 - SAMPLE_BITS;
	localparam int CNT_W = 6;
	localparam int DIV_STEPS = 34;
	localparam int MW = 63;
	localparam int MDW = 40;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_CORD  = 9'b000000010,
		ST_UNWR  = 9'b000000100,
		ST_SETUP = 9'b000001000,
		ST_MUL   = 9'b000010000,
		ST_DCHK  = 9'b000100000,
		ST_DIV   = 9'b001000000,
		ST_FIN   = 9'b010000000,
		ST_EMIT  = 9'b100000000
	} state_t;

	typedef struct packed {
		logic [31:0]        ph;
		logic [31:0]        fr;
		logic signed [32:0] dph;
		logic signed [32:0] dfr;
		logic               grp;
		logic               last;
	} job_t;

	state_t state_q;

	// cordic registers
	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [31:0]          w_q;
	logic                 last_q;

	// sweep state
	logic signed [15:0] prev_wrapped_q;
	logic [31:0]        unwrap_offset_q;
	logic [31:0]        ph_hist0_q, ph_hist1_q, fr_hist0_q, fr_hist1_q;
	logic [1:0]         sweep_pos_q;

	// result jobs
	job_t r1_q, r2_q;
	logic nres_q;
	logic res_idx_q;
	logic job_idx_q;
	logic [DELAY_W-1:0] pd_q, gd_q;
	logic               flag_q;

	// shared multiply / divide
	logic [MW-1:0]  mul_a_q, acc_q;
	logic [MDW-1:0] md_q, rem_q;
	logic [DIV_STEPS-1:0] num_q, quot_q;
	logic negn_q, negd_q, ovf_q;

	pugd_res_t out_q;
	logic      out_valid_q;

	// input sample extended and scaled
	logic signed [CW-1:0] re_w, im_w;
	assign re_w = {{(CW-SAMPLE_BITS){sample.resp_real[SAMPLE_BITS-1]}}, sample.resp_real} <<< SCALE;
	assign im_w = {{(CW-SAMPLE_BITS){sample.resp_imag[SAMPLE_BITS-1]}}, sample.resp_imag} <<< SCALE;

	// cordic micro-rotation
	logic [4:0]           sh;
	logic signed [CW-1:0] xs, ys;
	logic signed [ZW-1:0] at;
	assign sh = cnt_q[4:0];
	assign xs = x_q >>> sh;
	assign ys = y_q >>> sh;
	assign at = signed'(atan_units(sh));

	// unwrap of the new wrapped phase
	logic signed [15:0] phi;
	logic signed [17:0] delta;
	logic [31:0]        off_new, u;
	assign phi   = z_q[15:0];
	assign delta = 18'(phi) - 18'(prev_wrapped_q);
	always_comb begin
		off_new = unwrap_offset_q;
		if (sweep_pos_q == 2'd0) begin
			off_new = '0;
		end else if (delta > 18'sd32768) begin
			off_new = unwrap_offset_q - 32'd65536;
		end else if (delta < -18'sd32768) begin
			off_new = unwrap_offset_q + 32'd65536;
		end
	end
	assign u = {{16{phi[15]}}, phi} + off_new;

	// operands of the current delay
	job_t                 cur;
	logic signed [32:0]   j_dph, j_dfr;
	logic                 j_need;
	logic [32:0]          j_a, j_d;
	logic [MDW-1:0]       j_md;
	assign cur    = res_idx_q ? r2_q : r1_q;
	assign j_dph  = job_idx_q ? cur.dph : {cur.ph[31], cur.ph};
	assign j_dfr  = job_idx_q ? cur.dfr : {1'b0, cur.fr};
	assign j_need = job_idx_q ? cur.grp : (cur.fr != '0);
	assign j_a    = j_dph[32] ? 33'(-j_dph) : 33'(j_dph);
	assign j_d    = j_dfr[32] ? 33'(-j_dfr) : 33'(j_dfr);
	assign j_md   = {j_d[32:0], 7'd0};

	// zero denominator limit
	logic [DELAY_W-1:0] zero_val;
	assign zero_val = (j_a == '0) ? '0 : ((j_dph > 0) ? 32'h8000_0000 : 32'h7FFF_FFFF);

	// divide step
	logic [MDW:0] trial;
	logic         fits;
	assign trial = {rem_q, num_q[DIV_STEPS-1]};
	assign fits  = trial >= {1'b0, md_q};

	// sign and clamp of the quotient
	logic [DELAY_W-1:0] fin_val;
	logic               fin_sat;
	always_comb begin
		fin_sat = 1'b0;
		fin_val = '0;
		if (!ovf_q && quot_q == '0) begin
			fin_val = '0;
		end else if (negn_q != negd_q) begin
			if (ovf_q || quot_q > 34'h0_8000_0000) begin
				fin_sat = 1'b1;
				fin_val = 32'h8000_0000;
			end else begin
				fin_val = 32'(-quot_q);
			end
		end else if (ovf_q || quot_q > 34'h0_7FFF_FFFF) begin
			fin_sat = 1'b1;
			fin_val = 32'h7FFF_FFFF;
		end else begin
			fin_val = quot_q[31:0];
		end
	end

	assign sample.ready = (state_q == ST_IDLE);

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			prev_wrapped_q  <= '0;
			unwrap_offset_q <= '0;
			ph_hist0_q      <= '0;
			ph_hist1_q      <= '0;
			fr_hist0_q      <= '0;
			fr_hist1_q      <= '0;
			sweep_pos_q     <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			// result taken, the emit state refills it on its own
			if (out_valid_q && result.ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						w_q    <= sample.ang_freq;
						last_q <= sample.sweep_end;
						cnt_q  <= '0;
						if (re_w == '0 && im_w == '0) begin
							z_q     <= '0;
							state_q <= ST_UNWR;
						end else begin
							if (re_w < 0) begin
								z_q <= (im_w >= 0) ? ZW'(32768) : -ZW'(32768);
								x_q <= -re_w;
								y_q <= -im_w;
							end else begin
								z_q <= '0;
								x_q <= re_w;
								y_q <= im_w;
							end
							state_q <= ST_CORD;
						end
					end
				end
				ST_CORD: begin
					if (y_q > 0) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + at;
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - at;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
						state_q <= ST_UNWR;
					end
				end
				ST_UNWR: begin
					prev_wrapped_q <= phi;
					res_idx_q      <= 1'b0;
					job_idx_q      <= 1'b0;
					flag_q         <= 1'b0;
					unwrap_offset_q <= last_q ? '0 : off_new;
					if (sweep_pos_q == 2'd0) begin
						ph_hist1_q  <= u;
						fr_hist1_q  <= w_q;
						sweep_pos_q <= last_q ? 2'd0 : 2'd1;
						r1_q        <= '{ph: u, fr: w_q, dph: '0, dfr: '0, grp: 1'b0, last: 1'b1};
						nres_q      <= 1'b0;
						state_q     <= last_q ? ST_SETUP : ST_IDLE;
					end else begin
						r1_q <= '{ph: ph_hist1_q, fr: fr_hist1_q,
							dph: 33'(signed'(u)) - 33'(signed'((sweep_pos_q == 2'd1) ?
								ph_hist1_q : ph_hist0_q)),
							dfr: {1'b0, w_q} - {1'b0, (sweep_pos_q == 2'd1) ?
								fr_hist1_q : fr_hist0_q},
							grp: 1'b1, last: 1'b0};
						r2_q <= '{ph: u, fr: w_q,
							dph: 33'(signed'(u)) - 33'(signed'(ph_hist1_q)),
							dfr: {1'b0, w_q} - {1'b0, fr_hist1_q},
							grp: 1'b1, last: 1'b1};
						nres_q      <= last_q;
						ph_hist0_q  <= ph_hist1_q;
						fr_hist0_q  <= fr_hist1_q;
						ph_hist1_q  <= u;
						fr_hist1_q  <= w_q;
						sweep_pos_q <= last_q ? 2'd0 : 2'd2;
						state_q     <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (!j_need || j_md == '0) begin
						if (job_idx_q) begin
							gd_q <= j_need ? zero_val : '0;
						end else begin
							pd_q <= j_need ? zero_val : '0;
						end
						if (j_need) begin
							flag_q <= 1'b1;
						end
						job_idx_q <= 1'b1;
						if (job_idx_q) begin
							state_q <= ST_EMIT;
						end
					end else begin
						mul_a_q <= MW'(j_a);
						acc_q   <= '0;
						md_q    <= j_md;
						negn_q  <= j_dph > 0;
						negd_q  <= j_dfr < 0;
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (PI_Q28[cnt_q[4:0]]) begin
						acc_q <= acc_q + mul_a_q;
					end
					mul_a_q <= mul_a_q << 1;
					cnt_q   <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(PI_W - 1)) begin
						state_q <= ST_DCHK;
					end
				end
				ST_DCHK: begin
					ovf_q  <= {11'd0, acc_q[MW-1:DIV_STEPS]} >= md_q;
					rem_q  <= {11'd0, acc_q[MW-1:DIV_STEPS]};
					num_q  <= acc_q[DIV_STEPS-1:0];
					quot_q <= '0;
					cnt_q  <= '0;
					state_q <= ({11'd0, acc_q[MW-1:DIV_STEPS]} >= md_q) ? ST_FIN : ST_DIV;
				end
				ST_DIV: begin
					rem_q  <= fits ? MDW'(trial - {1'b0, md_q}) : trial[MDW-1:0];
					quot_q <= {quot_q[DIV_STEPS-2:0], fits};
					num_q  <= num_q << 1;
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (job_idx_q) begin
						gd_q <= fin_val;
					end else begin
						pd_q <= fin_val;
					end
					if (fin_sat) begin
						flag_q <= 1'b1;
					end
					job_idx_q <= 1'b1;
					state_q   <= job_idx_q ? ST_EMIT : ST_SETUP;
				end
				ST_EMIT: begin
					if (!out_valid_q || result.ready) begin
						out_q <= '{unwrapped_phase: cur.ph, phase_delay_out: pd_q,
							group_delay_out: gd_q, sat_flag: flag_q, final_result: cur.last};
						out_valid_q <= 1'b1;
						res_idx_q   <= 1'b1;
						job_idx_q   <= 1'b0;
						flag_q      <= 1'b0;
						state_q     <= (res_idx_q == nres_q) ? ST_IDLE : ST_SETUP;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result channel
	assign result.valid           = out_valid_q;
	assign result.unwrapped_phase = out_q.unwrapped_phase;
	assign result.phase_delay_out = out_q.phase_delay_out;
	assign result.group_delay_out = out_q.group_delay_out;
	assign result.sat_flag        = out_q.sat_flag;
	assign result.final_result    = out_q.final_result;

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Sweeps of complex response points are driven into the phase unwrap and
// group delay core. Each result is checked field by field against a bench
// predictor of phase, unwrap and delays, or a typed-in directed result.
// ----------------------------------------------------------------------------
module tb;
	import pugd_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pugd_in_if  #(.SAMPLE_BITS(16)) sample ();
	pugd_out_if result ();

	phase_unwrap_group_delay_core #(.SAMPLE_BITS(16), .CORDIC_STEPS(16)) uut (
		.clk(clk), .arst_n(arst_n), .sample(sample.sink), .result(result.source)
	);

	// clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one input request
	typedef struct packed {
		logic [15:0] re;
		logic [15:0] im;
		logic [31:0] w;
		logic        last;
	} point_t;

	// directed row: point plus optional typed-in result for the pending output
	typedef struct {
		point_t    pt;
		bit        has_exp;
		pugd_res_t exp_res;
	} row_t;

	// predictor state
	logic signed [15:0] pr_prev_wrapped;
	logic [31:0]        pr_offset;
	logic [31:0]        pr_phase_hist [2];
	logic [31:0]        pr_freq_hist [2];
	int                 pr_pos;

	pugd_res_t expected_results [$];
	point_t    stim_q [$];
	row_t      rows [$];
	int        errors = 0;
	int        idle_cycles = 0;
	bit        timed_out = 0;

	localparam int WATCHDOG = 20000;

	// vectoring rotation, 32768 units equal pi
	function automatic logic signed [15:0] vector_angle(logic signed [15:0] re,
		logic signed [15:0] im);
		longint x, y, z, nx;
		longint tbl [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5,
			3, 1, 1, 0};
		if (re == 0 && im == 0) return 16'sd0;
		x = longint'(re) <<< 32;
		y = longint'(im) <<< 32;
		z = 0;
		if (x < 0) begin
			z = (y >= 0) ? 32768 : -32768;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 16; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z += tbl[i];
			end else begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z -= tbl[i];
			end
			x = nx;
		end
		return z[15:0];
	endfunction

	// -dphase * pi_q28 / (dfreq * 128), clamped
	function automatic logic [31:0] delay_quot(longint dph, longint dfr, ref bit flag);
		bit neg_n, neg_d;
		logic [127:0] mn, md, q;
		neg_n = dph > 0;
		neg_d = dfr < 0;
		mn = 128'(dph < 0 ? -dph : dph) * 128'(PI_Q28);
		md = 128'(dfr < 0 ? -dfr : dfr) << 7;
		if (md == 0) begin
			flag = 1;
			if (mn == 0) return 32'd0;
			return neg_n ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		q = mn / md;
		if (q == 0) return 32'd0;
		if (neg_n != neg_d) begin
			if (q > 128'h8000_0000) begin
				flag = 1;
				q = 128'h8000_0000;
			end
			return 32'(-q[31:0]);
		end
		if (q > 128'h7FFF_FFFF) begin
			flag = 1;
			q = 128'h7FFF_FFFF;
		end
		return q[31:0];
	endfunction

	function automatic pugd_res_t make_result(logic [31:0] ph, logic [31:0] fr,
		longint dph, longint dfr, bit use_gd, bit last);
		pugd_res_t r;
		bit flag;
		flag = 0;
		r.unwrapped_phase = ph;
		r.phase_delay_out = 0;
		r.group_delay_out = 0;
		if (fr != 0) r.phase_delay_out = delay_quot(longint'(signed'(ph)), longint'(fr), flag);
		if (use_gd) r.group_delay_out = delay_quot(dph, dfr, flag);
		r.sat_flag = flag;
		r.final_result = last;
		return r;
	endfunction

	// advance the predictor by one point, queue what it yields
	task automatic predict_point(point_t p, bit has_exp, pugd_res_t exp_res);
		logic signed [15:0] phi;
		logic signed [31:0] delta;
		logic [31:0] u;
		int base;
		longint dph, dfr;
		pugd_res_t r;
		phi = vector_angle(p.re, p.im);
		if (pr_pos == 0) begin
			pr_offset = 0;
		end else begin
			delta = 32'(phi) - 32'(pr_prev_wrapped);
			if (delta > 32768) pr_offset -= 32'd65536;
			else if (delta < -32768) pr_offset += 32'd65536;
		end
		pr_prev_wrapped = phi;
		u = 32'(phi) + pr_offset;
		if (pr_pos == 0) begin
			pr_phase_hist[1] = u;
			pr_freq_hist[1] = p.w;
			pr_pos = 1;
			if (p.last) begin
				r = make_result(u, p.w, 0, 0, 0, 1);
				expected_results.push_back(has_exp ? exp_res : r);
			end
		end else begin
			base = (pr_pos == 1) ? 1 : 0;
			dph = longint'(signed'(u)) - longint'(signed'(pr_phase_hist[base]));
			dfr = longint'(p.w) - longint'(pr_freq_hist[base]);
			r = make_result(pr_phase_hist[1], pr_freq_hist[1], dph, dfr, 1, 0);
			expected_results.push_back(has_exp ? exp_res : r);
			pr_phase_hist[0] = pr_phase_hist[1];
			pr_freq_hist[0] = pr_freq_hist[1];
			pr_phase_hist[1] = u;
			pr_freq_hist[1] = p.w;
			pr_pos = 2;
			if (p.last) begin
				dph = longint'(signed'(u)) - longint'(signed'(pr_phase_hist[0]));
				dfr = longint'(p.w) - longint'(pr_freq_hist[0]);
				expected_results.push_back(make_result(u, p.w, dph, dfr, 1, 1));
			end
		end
		if (p.last) begin
			pr_pos = 0;
			pr_offset = 0;
		end
	endtask

	function automatic point_t pt(int re, int im, logic [31:0] w, bit last);
		point_t p;
		p.re = re[15:0];
		p.im = im[15:0];
		p.w = w;
		p.last = last;
		return p;
	endfunction

	function automatic pugd_res_t res(logic [31:0] ph, logic [31:0] pd, logic [31:0] gd,
		bit sat, bit last);
		pugd_res_t r;
		r.unwrapped_phase = ph;
		r.phase_delay_out = pd;
		r.group_delay_out = gd;
		r.sat_flag = sat;
		r.final_result = last;
		return r;
	endfunction

	task automatic add_row(point_t p, bit has_exp = 0, pugd_res_t e = '0);
		row_t r;
		r.pt = p;
		r.has_exp = has_exp;
		r.exp_res = e;
		rows.push_back(r);
	endtask

	// directed table
	initial begin
		// zero sample at zero frequency, single point sweep
		add_row(pt(0, 0, 0, 1), 1, res(0, 0, 0, 0, 1));
		// two zero samples, same frequency: zero denominator, zero numerator
		add_row(pt(0, 0, 5, 0));
		add_row(pt(0, 0, 5, 1), 1, res(0, 0, 0, 1, 0));
		// negative real axis, angle of pi wrapping
		add_row(pt(-32768, 0, 32'hFFFF_FFFF, 1));
		add_row(pt(-32768, -1, 256, 0));
		add_row(pt(-32768, 1, 256, 0));
		add_row(pt(-32768, -1, 1, 0));
		add_row(pt(32767, 32767, 0, 0));
		add_row(pt(-32768, 32767, 32'hFFFF_FFFF, 0));
		add_row(pt(-1, -32768, 0, 0));
		add_row(pt(32767, -32768, 32'h8000_0000, 0));
		add_row(pt(0, 32767, 1, 1));
		// three point sweep with wraps both ways
		add_row(pt(-30000, 100, 1000, 0));
		add_row(pt(-30000, -100, 2000, 0));
		add_row(pt(-30000, 100, 3000, 1));
		add_row(pt(1, 0, 0, 0));
		add_row(pt(0, -1, 0, 1));
	end

	// request driver: bursts and gaps, changes at falling edge
	initial begin
		int burst;
		int gap;
		sample.valid = 0;
		sample.resp_real = 0;
		sample.resp_imag = 0;
		sample.ang_freq = 0;
		sample.sweep_end = 0;
		result.ready = 0;
		#0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1;
		pr_prev_wrapped = 0;
		pr_offset = 0;
		pr_phase_hist = '{0, 0};
		pr_freq_hist = '{0, 0};
		pr_pos = 0;
		foreach (rows[i]) stim_q.push_back(rows[i].pt);
		// random sweeps, mostly short ones with random samples and frequencies
		begin
			int n, len, mode;
			logic [31:0] w;
			n = 0;
			while (n < 1300) begin
				len = $urandom_range(1, 6);
				mode = $urandom_range(0, 3);
				w = $urandom;
				for (int k = 0; k < len; k++) begin
					point_t p;
					p.re = $urandom;
					p.im = $urandom;
					if (mode == 0) p.w = $urandom;
					else if (mode == 1) p.w = w + 32'($urandom_range(0, 3));
					else p.w = $urandom_range(0, 4000) * (k + 1);
					if (mode == 2 && $urandom_range(0, 1)) p.re = -$urandom_range(1000, 32768);
					p.last = (k == len - 1) ? 1'b1 : ($urandom_range(0, 15) == 0);
					stim_q.push_back(p);
					n++;
				end
			end
		end
		for (int i = 0; i < stim_q.size(); i++) begin
			if (i < rows.size()) predict_point(stim_q[i], rows[i].has_exp, rows[i].exp_res);
			else predict_point(stim_q[i], 0, '0);
		end
		burst = 0;
		for (int i = 0; i < stim_q.size(); i++) begin
			if (burst == 0) begin
				gap = $urandom_range(0, 6);
				if (gap > 0) begin
					sample.valid <= 0;
					repeat (gap) @(negedge clk);
				end
				burst = $urandom_range(1, 12);
			end
			sample.valid <= 1;
			sample.resp_real <= stim_q[i].re;
			sample.resp_imag <= stim_q[i].im;
			sample.ang_freq <= stim_q[i].w;
			sample.sweep_end <= stim_q[i].last;
			@(posedge clk);
			while (!sample.ready) @(posedge clk);
			burst--;
			@(negedge clk);
		end
		sample.valid <= 0;
		while (expected_results.size() != 0 && !timed_out) @(posedge clk);
		repeat (300) @(posedge clk);
		if (!timed_out) begin
			if (errors == 0 && expected_results.size() == 0)
				$display("Test completed successfully");
			else
				$display("Test completed with failures");
			$finish;
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (arst_n) result.ready <= ($urandom_range(0, 9) < 6) || ($urandom_range(0, 3) == 0);
	end

	// result checker and watchdog
	always @(posedge clk) begin
		pugd_res_t e;
		if (arst_n) begin
			if ((sample.valid && sample.ready) || (result.valid && result.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG && !timed_out) begin
				timed_out = 1;
				$display("Test completed with failures");
				$finish;
			end
			if (result.valid && result.ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result phase %h", $time, result.unwrapped_phase);
				end else begin
					e = expected_results.pop_front();
					if (result.unwrapped_phase !== e.unwrapped_phase) begin
						errors++;
						$display("%0t: phase exp %h got %h", $time, e.unwrapped_phase,
							result.unwrapped_phase);
					end
					if (result.phase_delay_out !== e.phase_delay_out) begin
						errors++;
						$display("%0t: phase delay exp %h got %h", $time, e.phase_delay_out,
							result.phase_delay_out);
					end
					if (result.group_delay_out !== e.group_delay_out) begin
						errors++;
						$display("%0t: group delay exp %h got %h", $time, e.group_delay_out,
							result.group_delay_out);
					end
					if (result.sat_flag !== e.sat_flag) begin
						errors++;
						$display("%0t: sat flag exp %b got %b", $time, e.sat_flag,
							result.sat_flag);
					end
					if (result.final_result !== e.final_result) begin
						errors++;
						$display("%0t: final exp %b got %b", $time, e.final_result,
							result.final_result);
					end
				end
			end
		end
	end

endmodule

[files.f]
src/pugd_pkg.sv
src/pugd_in_if.sv
src/pugd_out_if.sv
src/phase_unwrap_group_delay_core.sv
sim/tb.sv
